@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked while reset is released.
`define CMW_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked at every edge, reset included.
`define CMW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CMW_ASSERT(lbl, clk, rstn, prop, msg)
`define CMW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ src/cmw_pkg.sv @@
// ---------------------------------------------------------------------------
// cmw_pkg
// Types and constants of the single-precision complex multiplier.
// ---------------------------------------------------------------------------
package cmw_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned NumStages = 9;

  localparam logic [WordW-1:0] CanonQnan = 32'h7FC0_0000;

  // Register map of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CfgMode = 3'd0,
    CfgFxRe = 3'd1,
    CfgFxIm = 3'd2,
    CfgFyRe = 3'd3,
    CfgFyIm = 3'd4
  } cmw_cfg_reg_e;

  // Unpacked single operand: value = man * 2^(ex - 23), man[23] set unless zero
  typedef struct packed {
    logic               sgn;
    logic signed [8:0]  ex;
    logic [23:0]        man;
    logic               zero;
    logic               inf;
    logic               nan;
  } cmw_op_t;

  // Stage enables of the product-sum lane, bit j drives lane stage j+1
  typedef logic [NumStages-2:0] cmw_dot_en_t;

endpackage

@@ src/cmw_in_if.sv @@
// ---------------------------------------------------------------------------
// cmw_in_if
// Operand channel: two complex singles and a last marker.
// ---------------------------------------------------------------------------
interface cmw_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_real;
  logic [31:0] x_imag;
  logic [31:0] y_real;
  logic [31:0] y_imag;
  logic        in_last;

  modport source (output valid, output x_real, output x_imag, output y_real,
                  output y_imag, output in_last, input ready);
  modport sink   (input valid, input x_real, input x_imag, input y_real,
                  input y_imag, input in_last, output ready);
endinterface

@@ src/cmw_out_if.sv @@
// ---------------------------------------------------------------------------
// cmw_out_if
// Result channel: one complex single and a last marker.
// ---------------------------------------------------------------------------
interface cmw_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] z_real;
  logic [31:0] z_imag;
  logic        out_last;

  modport source (output valid, output z_real, output z_imag, output out_last,
                  input ready);
  modport sink   (input valid, input z_real, input z_imag, input out_last,
                  output ready);
endinterface

@@ src/cmw_dot.sv @@
// ---------------------------------------------------------------------------
// cmw_dot
// Pipelined a*b +/- c*d with exact products, rounded to double then single.
// ---------------------------------------------------------------------------
module cmw_dot (
  input  logic                  clk_i,
  input  cmw_pkg::cmw_dot_en_t  en_i,
  input  logic                  sub_i,
  input  cmw_pkg::cmw_op_t      a_i,
  input  cmw_pkg::cmw_op_t      b_i,
  input  cmw_pkg::cmw_op_t      c_i,
  input  cmw_pkg::cmw_op_t      d_i,
  output logic [31:0]           z_o
);
  import cmw_pkg::*;

  function automatic logic [6:0] lzc66(input logic [65:0] v);
    logic [6:0] n;
    n = 7'd66;
    for (int i = 0; i < 66; i++) begin
      if (v[i]) n = 7'(65 - i);
    end
    return n;
  endfunction

  // ---- stage 1: exact products -------------------------------------------
  logic [47:0]       pm_q, qm_q;
  logic signed [9:0] pe_q, qe_q;
  logic              ps_q, qs_q, pz_q, qz_q, pi_q, qi_q, pn_q, qn_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pm_q <= a_i.man * b_i.man;
      qm_q <= c_i.man * d_i.man;
      pe_q <= $signed({a_i.ex[8], a_i.ex}) + $signed({b_i.ex[8], b_i.ex}) + 10'sd1;
      qe_q <= $signed({c_i.ex[8], c_i.ex}) + $signed({d_i.ex[8], d_i.ex}) + 10'sd1;
      ps_q <= a_i.sgn ^ b_i.sgn;
      qs_q <= c_i.sgn ^ d_i.sgn ^ sub_i;
      pz_q <= a_i.zero | b_i.zero;
      qz_q <= c_i.zero | d_i.zero;
      pi_q <= a_i.inf | b_i.inf;
      qi_q <= c_i.inf | d_i.inf;
      pn_q <= a_i.nan | b_i.nan | (a_i.inf & b_i.zero) | (a_i.zero & b_i.inf);
      qn_q <= c_i.nan | d_i.nan | (c_i.inf & d_i.zero) | (c_i.zero & d_i.inf);
    end
  end

  // ---- stage 2: specials, swap, align ------------------------------------
  logic              swap;
  logic [47:0]       bm, sm;
  logic signed [9:0] be, se;
  logic signed [10:0] dexp;
  logic [6:0]        dsat;
  logic [64:0]       sext, sshift, smask;
  logic              sticky2;
  logic              spec2;
  logic [31:0]       specv2;

  always_comb begin
    swap   = pz_q | (!qz_q && ($signed(qe_q) > $signed(pe_q)));
    bm     = swap ? qm_q : pm_q;
    sm     = swap ? pm_q : qm_q;
    be     = swap ? qe_q : pe_q;
    se     = swap ? pe_q : qe_q;
    dexp   = $signed({be[9], be}) - $signed({se[9], se});
    dsat   = (dexp < 11'sd0 || dexp > 11'sd66) ? 7'd66 : 7'(dexp);
    sext   = {sm, 17'd0};
    sshift = sext >> dsat;
    smask  = ~({65{1'b1}} << dsat);
    sticky2 = |(sext & smask);
    spec2  = pn_q | qn_q | pi_q | qi_q | (pz_q & qz_q);
    if (pn_q || qn_q || (pi_q && qi_q && (ps_q != qs_q))) begin
      specv2 = CanonQnan;
    end else if (pi_q || qi_q) begin
      specv2 = {(pi_q ? ps_q : qs_q), 8'hFF, 23'd0};
    end else begin
      specv2 = {ps_q & qs_q, 31'd0};
    end
  end

  logic [64:0]       a2_q, b2_q;
  logic signed [9:0] e2_q;
  logic              s2_q, sub2_q, spec2_q;
  logic [31:0]       specv2_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      a2_q     <= {bm, 17'd0};
      b2_q     <= sshift | {64'd0, sticky2};
      e2_q     <= be;
      s2_q     <= swap ? qs_q : ps_q;
      sub2_q   <= ps_q ^ qs_q;
      spec2_q  <= spec2;
      specv2_q <= specv2;
    end
  end

  // ---- stage 3: add or subtract ------------------------------------------
  logic [65:0] sum3, dab3, dba3, res3;
  logic        s3;

  always_comb begin
    sum3 = {1'b0, a2_q} + {1'b0, b2_q};
    dab3 = {1'b0, a2_q} - {1'b0, b2_q};
    dba3 = {1'b0, b2_q} - {1'b0, a2_q};
    s3   = s2_q;
    if (!sub2_q) begin
      res3 = sum3;
    end else if (dab3[65]) begin
      res3 = dba3;
      s3   = ~s2_q;
    end else begin
      res3 = dab3;
    end
  end

  logic [65:0]       r3_q;
  logic signed [9:0] e3_q;
  logic              s3_q, z3_q, spec3_q;
  logic [31:0]       specv3_q;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      r3_q     <= res3;
      e3_q     <= e2_q;
      s3_q     <= s3;
      z3_q     <= (res3 == 66'd0);
      spec3_q  <= spec2_q;
      specv3_q <= specv2_q;
    end
  end

  // ---- stage 4: leading zero count ---------------------------------------
  logic [65:0]       r4_q;
  logic [6:0]        lz4_q;
  logic signed [9:0] e4_q;
  logic              s4_q, z4_q, spec4_q;
  logic [31:0]       specv4_q;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      r4_q     <= r3_q;
      lz4_q    <= lzc66(r3_q);
      e4_q     <= e3_q;
      s4_q     <= s3_q;
      z4_q     <= z3_q;
      spec4_q  <= spec3_q;
      specv4_q <= specv3_q;
    end
  end

  // ---- stage 5: normalise, leading one at bit 65 -------------------------
  logic [65:0]        n5_q;
  logic signed [11:0] e5_q;
  logic               s5_q, z5_q, spec5_q;
  logic [31:0]        specv5_q;

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      n5_q     <= r4_q << lz4_q;
      e5_q     <= $signed({{2{e4_q[9]}}, e4_q}) + 12'sd1 - $signed({5'd0, lz4_q});
      s5_q     <= s4_q;
      z5_q     <= z4_q;
      spec5_q  <= spec4_q;
      specv5_q <= specv4_q;
    end
  end

  // ---- stage 6: round to 53 bits -----------------------------------------
  logic        inc6;
  logic [53:0] m6;

  always_comb begin
    inc6 = n5_q[12] & ((|n5_q[11:0]) | n5_q[13]);
    m6   = {1'b0, n5_q[65:13]} + {53'd0, inc6};
  end

  logic [52:0]        m6_q;
  logic signed [11:0] e6_q;
  logic               s6_q, z6_q, spec6_q;
  logic [31:0]        specv6_q;

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      m6_q     <= m6[53] ? m6[53:1] : m6[52:0];
      e6_q     <= m6[53] ? e5_q + 12'sd1 : e5_q;
      s6_q     <= s5_q;
      z6_q     <= z5_q;
      spec6_q  <= spec5_q;
      specv6_q <= specv5_q;
    end
  end

  // ---- stage 7: align to single, subnormal shift -------------------------
  logic signed [11:0] eb7, sh7w;
  logic [4:0]         sh7;
  logic [7:0]         expf7;
  logic [77:0]        w7;
  logic               inc7;

  always_comb begin
    eb7  = e6_q + 12'sd127;
    sh7w = 12'sd1 - eb7;
    if (eb7 >= 12'sd1) begin
      sh7   = 5'd0;
      expf7 = eb7[7:0];
    end else begin
      sh7   = (sh7w > 12'sd26) ? 5'd26 : sh7w[4:0];
      expf7 = 8'd0;
    end
    w7   = {m6_q, 25'd0} >> sh7;
    inc7 = w7[53] & ((|w7[52:0]) | w7[54]);
  end

  logic [30:0] pk7_q;
  logic        inc7_q, ovf7_q, s7_q, z7_q, spec7_q;
  logic [31:0] specv7_q;

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      pk7_q    <= {expf7, w7[76:54]};
      inc7_q   <= inc7;
      ovf7_q   <= (eb7 >= 12'sd255);
      s7_q     <= s6_q;
      z7_q     <= z6_q;
      spec7_q  <= spec6_q;
      specv7_q <= specv6_q;
    end
  end

  // ---- stage 8: round and pack -------------------------------------------
  logic [31:0] z8;

  always_comb begin
    if (spec7_q) begin
      z8 = specv7_q;
    end else if (z7_q) begin
      z8 = 32'd0;
    end else if (ovf7_q) begin
      z8 = {s7_q, 8'hFF, 23'd0};
    end else begin
      z8 = {s7_q, pk7_q + {30'd0, inc7_q}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      z_o <= z8;
    end
  end

endmodule

@@ src/complex_mul_single_wide.sv @@
// ---------------------------------------------------------------------------
// complex_mul_single_wide
// Streaming single-precision complex multiplier, z = x * y, with broadcast.
// ---------------------------------------------------------------------------
//
//  channel   dir  handshake        payload
//  in_ch     in   valid/ready      x_real x_imag y_real y_imag in_last
//  out_ch    out  valid/ready      z_real z_imag out_last
//  cfg       in   cfg_we_i only    cfg_idx_i cfg_data_i
//
//  One complex pair per cycle unless the output stalls; a result passes
//  through one unpack stage and then eight stages in each lane.
//  Each stage holds its own valid bit and is released when it is empty or
//  the stage after it moves, so bubbles close up under an output stall.
//  Reset clears the valid bits and the configuration registers.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module complex_mul_single_wide (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  cmw_in_if.sink                       in_ch,
  cmw_out_if.source                    out_ch,
  input  logic                         cfg_we_i,
  input  logic [cmw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cmw_pkg::WordW-1:0]    cfg_data_i
);
  import cmw_pkg::*;

  // Split a single into sign, exponent and a normalised 24-bit significand;
  // subnormals are shifted up so that every lane sees a leading one.
  function automatic cmw_op_t unpack(input logic [31:0] w);
    cmw_op_t    o;
    logic [4:0] lz;
    lz = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (w[i]) lz = 5'(22 - i);
    end
    o.sgn  = w[31];
    o.zero = (w[30:23] == 8'd0) && (w[22:0] == 23'd0);
    o.inf  = (w[30:23] == 8'hFF) && (w[22:0] == 23'd0);
    o.nan  = (w[30:23] == 8'hFF) && (w[22:0] != 23'd0);
    if (w[30:23] == 8'd0) begin
      o.man = {w[22:0], 1'b0} << lz;
      o.ex  = -9'sd127 - $signed({4'd0, lz});
    end else begin
      o.man = {1'b1, w[22:0]};
      o.ex  = $signed({1'b0, w[30:23]}) - 9'sd127;
    end
    return o;
  endfunction

  // ---- configuration registers -------------------------------------------
  logic [1:0]  mode_q;
  logic [31:0] fx_re_q, fx_im_q, fy_re_q, fy_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 2'd0;
      fx_re_q <= '0;
      fx_im_q <= '0;
      fy_re_q <= '0;
      fy_im_q <= '0;
    end else if (cfg_we_i) begin
      case (cmw_cfg_reg_e'(cfg_idx_i))
        CfgMode: mode_q  <= cfg_data_i[1:0];
        CfgFxRe: fx_re_q <= cfg_data_i;
        CfgFxIm: fx_im_q <= cfg_data_i;
        CfgFyRe: fy_re_q <= cfg_data_i;
        CfgFyIm: fy_im_q <= cfg_data_i;
        default: ;  // drop writes beyond the register map
      endcase
    end
  end

  // ---- stage enables and valid bits --------------------------------------
  // en[k] releases stage k; en[NumStages] is the downstream ready.
  logic [NumStages:0]   en;
  logic [NumStages-1:0] vld_d, vld_q;

  always_comb begin
    en[NumStages] = out_ch.ready;
    for (int k = NumStages - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < NumStages; k++) begin
      if (!en[k]) begin
        vld_d[k] = vld_q[k];
      end else if (k == 0) begin
        vld_d[k] = in_ch.valid;
      end else begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ch.ready = en[0];

  // ---- last marker travels alongside the lanes ---------------------------
  logic last_q [NumStages];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      last_q[0] <= in_ch.in_last;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) begin
        last_q[k] <= last_q[k-1];
      end
    end
  end

  // ---- stage 0: broadcast select and unpack ------------------------------
  logic [31:0] sel_xr, sel_xi, sel_yr, sel_yi;
  cmw_op_t     xr_q, xi_q, yr_q, yi_q;

  always_comb begin
    sel_xr = mode_q[0] ? fx_re_q : in_ch.x_real;
    sel_xi = mode_q[0] ? fx_im_q : in_ch.x_imag;
    sel_yr = mode_q[1] ? fy_re_q : in_ch.y_real;
    sel_yi = mode_q[1] ? fy_im_q : in_ch.y_imag;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      xr_q <= unpack(sel_xr);
      xi_q <= unpack(sel_xi);
      yr_q <= unpack(sel_yr);
      yi_q <= unpack(sel_yi);
    end
  end

  // ---- lanes: real = xr*yr - xi*yi, imaginary = xr*yi + xi*yr ------------
  cmw_dot_en_t lane_en;
  assign lane_en = en[NumStages-1:1];

  cmw_dot u_re (
    .clk_i (clk_i),
    .en_i  (lane_en),
    .sub_i (1'b1),
    .a_i   (xr_q),
    .b_i   (yr_q),
    .c_i   (xi_q),
    .d_i   (yi_q),
    .z_o   (out_ch.z_real)
  );

  cmw_dot u_im (
    .clk_i (clk_i),
    .en_i  (lane_en),
    .sub_i (1'b0),
    .a_i   (xr_q),
    .b_i   (yi_q),
    .c_i   (xi_q),
    .d_i   (yr_q),
    .z_o   (out_ch.z_imag)
  );

  assign out_ch.valid    = vld_q[NumStages-1];
  assign out_ch.out_last = last_q[NumStages-1];

  // ---- assertions --------------------------------------------------------
  `CMW_ASSERT(a_in_lands, clk_i, rst_ni, in_ch.valid && in_ch.ready |=> vld_q[0], "transfer in lost at stage 0")
  `CMW_ASSERT(a_full_stall, clk_i, rst_ni, (&vld_q) && !out_ch.ready |-> !in_ch.ready, "full pipeline took a transfer")
  `CMW_ASSERT(a_tail_hold, clk_i, rst_ni, out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.z_real) && $stable(out_ch.z_imag), "stalled result changed")
  `CMW_ASSERT(a_qnan_re, clk_i, rst_ni, out_ch.valid && (out_ch.z_real[30:23] == 8'hFF) && (out_ch.z_real[22:0] != 23'd0) |-> out_ch.z_real == CanonQnan, "real NaN not canonical")
  `CMW_ASSERT(a_qnan_im, clk_i, rst_ni, out_ch.valid && (out_ch.z_imag[30:23] == 8'hFF) && (out_ch.z_imag[22:0] != 23'd0) |-> out_ch.z_imag == CanonQnan, "imaginary NaN not canonical")

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench of the single-precision complex multiplier. Operand
// pairs are streamed in over the input channel; each transfer is predicted
// with double arithmetic and explicit rounding to single, and every result
// transfer is compared against the oldest pending product.
// ---------------------------------------------------------------------------
module tb_top;
  import cmw_pkg::*;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned DrainCycles   = 2 * NumStages + 4;
  localparam int unsigned HoldOffCycles = 400;
  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;   // outside the register map

  typedef struct packed {
    logic [31:0] xr;
    logic [31:0] xi;
    logic [31:0] yr;
    logic [31:0] yi;
    logic        last;
  } operand_t;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        last;
  } product_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [WordW-1:0]   cfg_data_i;

  cmw_in_if  in_ch ();
  cmw_out_if out_ch ();

  complex_mul_single_wide uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Mirror of the configuration registers, updated on every write
  logic [1:0]  bc_mode;
  logic [31:0] bc_xr, bc_xi, bc_yr, bc_yi;

  product_t    product_q[$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  bit          idle_en;      // random gaps on both channels
  bit          hold_req;     // ask the sink process for a long hold-off
  int unsigned hold_cnt;

  // -------------------------------------------------------------------------
  // Clock, and the sink ready with its gaps and hold-off
  // -------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.x_real  = '0;
    in_ch.x_imag  = '0;
    in_ch.y_real  = '0;
    in_ch.y_imag  = '0;
    in_ch.in_last = 1'b0;
    out_ch.ready  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgMode;
    cfg_data_i    = '0;
    idle_en       = 1'b0;
    hold_req      = 1'b0;
    hold_cnt      = 0;
  end

  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HoldOffCycles;
    end
    if (hold_cnt != 0) begin
      hold_cnt = hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 99) < 20) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // -------------------------------------------------------------------------
  // Predictor: widen exactly, one double rounding per part, then to single
  // -------------------------------------------------------------------------
  function automatic real sgl_to_dbl(input logic [31:0] w);
    logic [63:0] d;
    logic [23:0] m;
    int          k;
    k = 0;
    m = {1'b0, w[22:0]};
    if (w[30:23] == 8'hFF) begin
      d = (w[22:0] == 0) ? {w[31], 11'h7FF, 52'h0} : 64'h7FF8_0000_0000_0000;
    end else if (w[30:23] == 8'h00) begin
      if (m == 0) begin
        d = {w[31], 63'h0};
      end else begin
        // subnormal: normalise into the double exponent range
        while (!m[23]) begin
          m = m << 1;
          k++;
        end
        d = {w[31], 11'(1023 - 126 - k), m[22:0], 29'h0};
      end
    end else begin
      d = {w[31], 11'(w[30:23]) + 11'd896, w[22:0], 29'h0};
    end
    return $bitstoreal(d);
  endfunction

  function automatic logic [31:0] dbl_to_sgl(input real r);
    logic [63:0] d;
    logic [63:0] mant, q, rem, half;
    int          e, sh;
    d = $realtobits(r);
    if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? CanonQnan : {d[63], 8'hFF, 23'h0};
    if (d[62:52] == 11'h000) return {d[63], 31'h0};  // far below the single range
    e    = int'(d[62:52]) - 1023;
    mant = {11'h0, 1'b1, d[51:0]};
    if (e > 127) return {d[63], 8'hFF, 23'h0};
    if (e >= -126) begin
      q    = mant >> 29;
      rem  = mant & 64'h1FFF_FFFF;
      half = 64'h1000_0000;
      if (rem > half || (rem == half && q[0])) q = q + 1;
      // hidden bit lands in the exponent field; a carry out gives infinity
      return {d[63], 31'((64'(e + 126) << 23) + q)};
    end
    sh = -(e + 97);
    if (sh > 60) return {d[63], 31'h0};
    q    = mant >> sh;
    rem  = mant & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 1;
    return {d[63], q[30:0]};
  endfunction

  function automatic product_t complex_product(input operand_t op);
    product_t p;
    logic [31:0] axr, axi, ayr, ayi;
    real xr, xi, yr, yi;
    axr = op.xr; axi = op.xi; ayr = op.yr; ayi = op.yi;
    if (bc_mode[0]) begin
      axr = bc_xr;
      axi = bc_xi;
    end
    if (bc_mode[1]) begin
      ayr = bc_yr;
      ayi = bc_yi;
    end
    xr = sgl_to_dbl(axr);
    xi = sgl_to_dbl(axi);
    yr = sgl_to_dbl(ayr);
    yi = sgl_to_dbl(ayi);
    p.re   = dbl_to_sgl(xr * yr - xi * yi);
    p.im   = dbl_to_sgl(xr * yi + xi * yr);
    p.last = op.last;
    return p;
  endfunction

  // -------------------------------------------------------------------------
  // Result checker: compare each output transfer with the oldest product
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin
    product_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (product_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result re=%h im=%h last=%b", $realtime,
                   out_ch.z_real, out_ch.z_imag, out_ch.out_last);
      end else begin
        want = product_q.pop_front();
        if (out_ch.z_real !== want.re || out_ch.z_imag !== want.im ||
            out_ch.out_last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch re exp %h got %h, im exp %h got %h, last exp %b got %b",
                     $realtime, want.re, out_ch.z_real, want.im, out_ch.z_imag,
                     want.last, out_ch.out_last);
        end
      end
    end
  end

  // Watchdog: cycles with no transfer on any port
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we_i ||
        !rst_ni) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog expired, %0d results pending", $realtime, product_q.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Shared tasks
  // -------------------------------------------------------------------------
  task automatic send_item(input operand_t op);
    int unsigned gap;
    // idle the input only between transfers, never mid-offer
    if (idle_en && $urandom_range(0, 99) < 20) begin
      gap = $urandom_range(1, 4);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.x_real  <= op.xr;
    in_ch.x_imag  <= op.xi;
    in_ch.y_real  <= op.yr;
    in_ch.y_imag  <= op.yi;
    in_ch.in_last <= op.last;
    do @(posedge clk_i); while (!in_ch.ready);
    product_q.push_back(complex_product(op));
  endtask

  task automatic end_stream();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait for every pending product, then let the pipeline settle
  task automatic drain();
    end_stream();
    while (product_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CfgMode: bc_mode = data[1:0];
      CfgFxRe: bc_xr   = data;
      CfgFxIm: bc_xi   = data;
      CfgFyRe: bc_yr   = data;
      CfgFyIm: bc_yi   = data;
      default: ;  // writes outside the map are dropped
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] special_word(input int unsigned k);
    case (k)
      0:  return 32'h0000_0000;   // +0
      1:  return 32'h3F80_0000;   // 1.0
      2:  return 32'h7F80_0000;   // inf
      3:  return 32'h7FC0_0000;   // quiet NaN
      4:  return 32'h7F80_0001;   // signalling NaN
      5:  return 32'h7F7F_FFFF;   // largest finite
      6:  return 32'h0000_0001;   // smallest subnormal
      7:  return 32'h0080_0000;   // smallest normal
      8:  return 32'h007F_FFFF;   // largest subnormal
      default: return 32'h3FFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    logic [31:0] sw;
    sw = special_word($urandom_range(0, 9));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4:    return {1'($urandom), sw[30:0]};
      5, 6: return {1'($urandom), 8'($urandom_range(100, 154)), 23'($urandom)};
      7:    return {1'($urandom), 8'h00, 23'($urandom)};
      8:    return {1'($urandom), 8'($urandom_range(190, 254)), 23'($urandom)};
      default: return {1'($urandom), 8'($urandom_range(1, 40)), 23'($urandom)};
    endcase
  endfunction

  // Random pair; a share of them are near-cancelling so the sum loses bits
  function automatic operand_t rand_operand();
    operand_t op;
    op.xr   = rand_word();
    op.xi   = rand_word();
    op.yr   = rand_word();
    op.yi   = rand_word();
    op.last = 1'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      op.xi = op.xr ^ 32'($urandom_range(0, 3));
      op.yi = op.yr ^ 32'($urandom_range(0, 3));
      if ($urandom_range(0, 1) == 1) op.yi[31] = ~op.yi[31];
    end
    return op;
  endfunction

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  task automatic test_special_values();
    operand_t op;
    int unsigned k;
    // each special value in every slot, against rotated partners
    for (k = 0; k < 10; k++) begin
      op.xr   = special_word(k);
      op.xi   = special_word((k + 3) % 10);
      op.yr   = special_word((k + 7) % 10) | 32'h8000_0000;
      op.yi   = special_word((k + 5) % 10);
      op.last = k[0];
      send_item(op);
    end
    send_item('{32'h7F80_0000, 32'h7F80_0000, 32'h7F80_0000, 32'h7F80_0000, 1'b1}); // inf-inf
    send_item('{32'h0000_0000, 32'h8000_0000, 32'hFF80_0000, 32'h3F80_0000, 1'b0}); // 0*inf
    send_item('{32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b1}); // exact cancel
    send_item('{32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1'b0}); // signed zeros
    send_item('{32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b1}); // overflow
    send_item('{32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h8000_0001, 1'b0}); // underflow
    send_item('{32'hFFFF_FFFF, 32'hFFC1_2345, 32'h3F80_0000, 32'h0000_0000, 1'b1}); // NaN payloads
    send_item('{32'h1F80_0000, 32'h0000_0000, 32'h1F80_0001, 32'h0000_0000, 1'b0}); // to subnormal
    send_item('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1});
    send_item('{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0});
    drain();
  endtask

  task automatic test_broadcast();
    int unsigned m, n;
    // extremes of the fixed operands first, then other fixed values
    write_reg(CfgFxRe, 32'hFFFF_FFFF);
    write_reg(CfgFxIm, 32'h0000_0000);
    write_reg(CfgFyRe, 32'h7F7F_FFFF);
    write_reg(CfgFyIm, 32'h0000_0001);
    write_reg(CfgUnused, 32'h3F80_0000);
    for (m = 1; m <= 3; m++) begin
      write_reg(CfgMode, 32'(m) | 32'hFFFF_FFFC);  // upper bits must be dropped
      for (n = 0; n < 8; n++) send_item(rand_operand());
      drain();
    end
    write_reg(CfgFxRe, 32'h3F80_0000);
    write_reg(CfgFxIm, 32'hBF80_0000);
    write_reg(CfgFyRe, 32'h0000_0000);
    write_reg(CfgFyIm, 32'hFFFF_FFFF);
    for (m = 1; m <= 3; m++) begin
      write_reg(CfgMode, 32'(m));
      for (n = 0; n < 8; n++) send_item(rand_operand());
      drain();
    end
    write_reg(CfgMode, 32'h0);
  endtask

  task automatic test_random_stream();
    int unsigned ph, n;
    for (ph = 0; ph < 6; ph++) begin
      // phase two runs with no idling at all
      idle_en = (ph != 2);
      if (ph > 0) begin
        write_reg(CfgFxRe, rand_word());
        write_reg(CfgFxIm, rand_word());
        write_reg(CfgFyRe, rand_word());
        write_reg(CfgFyIm, rand_word());
        write_reg(CfgMode, (ph % 3 == 0) ? 32'h0 : 32'($urandom_range(0, 3)));
      end
      for (n = 0; n < 280; n++) send_item(rand_operand());
      drain();
    end
    idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    int unsigned n;
    write_reg(CfgMode, 32'h0);
    idle_en  = 1'b0;
    hold_req = 1'b1;   // sink holds off while the source keeps offering
    for (n = 0; n < 120; n++) send_item(rand_operand());
    drain();
    idle_en = 1'b1;
  endtask

  initial begin
    bc_mode = '0;
    bc_xr = '0; bc_xi = '0; bc_yr = '0; bc_yi = '0;
    mismatches  = 0;
    idle_cycles = 0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_en = 1'b1;
    test_special_values();
    test_broadcast();
    test_random_stream();
    test_backpressure();

    if (mismatches == 0 && product_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
